// File: sv/pra_pkg.sv
package pra_pkg;

  localparam int PAGE_W = 15;
  localparam int ADDR_W = 28;
  localparam int COUNT_W = 8;

  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_FREE = 2'd1;
  localparam logic [1:0] KIND_INIT = 2'd2;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_BAD_ADDRESS = 2'd1;
  localparam logic [1:0] STATUS_DOUBLE_FREE = 2'd2;
  localparam logic [1:0] STATUS_OUT_OF_MEMORY = 2'd3;

  localparam logic [COUNT_W-1:0] COUNT_ZERO = '0;
  localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] address;
  } req_t;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic [1:0]        status;
    logic              released;
  } rsp_t;

endpackage

// File: sv/pra_ram.sv
module pra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/page_refcount_allocator_unit.sv
// Page allocator with a reference count per page and a LIFO stack of free pages, both held
// in RAMs with a registered read. For an allocate or free word, the accept reads the stack
// top and the page count; in the execute state, once the output slot is free, the updated
// count is written and, for a release, the page is pushed. An initialize word walks every
// page once through the count RAM write port. After reset the block runs a clearing pass
// over every page that sets every count to one; it accepts no word until that pass ends,
// while configuration writes are taken at any time. A finished result waits in an
// output register; the next word is still accepted but cannot finish until that result is
// taken.
module page_refcount_allocator_unit #(
  parameter int NUM_PAGES = 32768,
  parameter int PAGE_BYTES = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  pra_pkg::req_t        req,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output pra_pkg::rsp_t        rsp,
  input  logic                 cfg_we,
  input  logic [pra_pkg::PAGE_W-1:0] cfg_data
);

  import pra_pkg::*;

  localparam int PGW = $clog2(NUM_PAGES);
  localparam int DW = $clog2(NUM_PAGES + 1);
  localparam int OFFW = $clog2(PAGE_BYTES);
  localparam int IDXW = ADDR_W - OFFW;
  localparam logic [PGW-1:0] LAST_PAGE = PGW'(NUM_PAGES - 1);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_SWEEP = 2'd3;

  logic [1:0]        state, state_next;
  logic [PGW-1:0]    sweep_pg, sweep_pg_next;
  logic [DW-1:0]     depth, depth_next;
  logic [PAGE_W-1:0] first_free_page;
  logic [1:0]        kind_r;
  logic [PGW-1:0]    pg_r;
  logic              bad_r;
  logic              rsp_valid_next;
  rsp_t              rsp_next;

  logic              accept;
  logic              slot_free;
  logic [IDXW-1:0]   req_idx;
  logic              req_bad;
  logic              can_push;
  logic              sweep_free;

  logic               count_we;
  logic [PGW-1:0]     count_waddr;
  logic [COUNT_W-1:0] count_wdata;
  logic [COUNT_W-1:0] count_rdata;
  logic [COUNT_W-1:0] count_dec;
  logic               stack_we;
  logic [PGW-1:0]     stack_waddr;
  logic [PGW-1:0]     stack_wdata;
  logic [PGW-1:0]     stack_rdata;

  assign req_ready = (state == S_IDLE);
  assign accept = req_valid && req_ready;
  assign slot_free = !rsp_valid || rsp_ready;
  assign req_idx = req.address[ADDR_W-1:OFFW];
  assign req_bad = (req.address[OFFW-1:0] != '0) ||
                   (32'(req_idx) < 32'(first_free_page)) ||
                   (32'(req_idx) >= 32'(NUM_PAGES));
  assign can_push = 32'(depth) < 32'(NUM_PAGES);
  assign sweep_free = 32'(sweep_pg) >= 32'(first_free_page);
  assign count_dec = count_rdata - COUNT_ONE;

  pra_ram #(
    .WIDTH(COUNT_W),
    .DEPTH(NUM_PAGES)
  ) u_count_ram (
    .clk  (clk),
    .we   (count_we),
    .waddr(count_waddr),
    .wdata(count_wdata),
    .re   (accept),
    .raddr(PGW'(req_idx)),
    .rdata(count_rdata)
  );

  pra_ram #(
    .WIDTH(PGW),
    .DEPTH(NUM_PAGES)
  ) u_stack_ram (
    .clk  (clk),
    .we   (stack_we),
    .waddr(stack_waddr),
    .wdata(stack_wdata),
    .re   (accept),
    .raddr(PGW'(depth - DW'(1))),
    .rdata(stack_rdata)
  );

  always_comb begin
    state_next = state;
    sweep_pg_next = sweep_pg;
    depth_next = depth;
    rsp_valid_next = rsp_valid && !rsp_ready;
    rsp_next = rsp;
    count_we = 1'b0;
    count_waddr = sweep_pg;
    count_wdata = COUNT_ONE;
    stack_we = 1'b0;
    stack_waddr = PGW'(depth);
    stack_wdata = sweep_pg;
    case (state)
      S_CLEAR: begin
        count_we = 1'b1;
        sweep_pg_next = sweep_pg + PGW'(1);
        if (sweep_pg == LAST_PAGE) begin
          sweep_pg_next = '0;
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (req.kind == KIND_INIT) begin
            depth_next = '0;
            sweep_pg_next = '0;
            state_next = S_SWEEP;
          end else begin
            state_next = S_EXEC;
          end
        end
      end
      S_SWEEP: begin
        count_we = 1'b1;
        count_wdata = sweep_free ? COUNT_ZERO : COUNT_ONE;
        if (sweep_free && can_push) begin
          stack_we = 1'b1;
          depth_next = depth + DW'(1);
        end
        sweep_pg_next = sweep_pg + PGW'(1);
        if (sweep_pg == LAST_PAGE) begin
          sweep_pg_next = '0;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          rsp_valid_next = 1'b1;
          rsp_next = '0;
          state_next = S_IDLE;
          case (kind_r)
            KIND_ALLOC: begin
              if (depth == '0) begin
                rsp_next.status = STATUS_OUT_OF_MEMORY;
              end else begin
                count_we = 1'b1;
                count_waddr = stack_rdata;
                count_wdata = COUNT_ONE;
                depth_next = depth - DW'(1);
                rsp_next.page = PAGE_W'(stack_rdata);
              end
            end
            KIND_FREE: begin
              if (bad_r) begin
                rsp_next.status = STATUS_BAD_ADDRESS;
              end else if (count_rdata == COUNT_ZERO) begin
                rsp_next.status = STATUS_DOUBLE_FREE;
                rsp_next.page = PAGE_W'(pg_r);
              end else begin
                rsp_next.page = PAGE_W'(pg_r);
                count_we = 1'b1;
                count_waddr = pg_r;
                count_wdata = count_dec;
                if (count_dec == COUNT_ZERO) begin
                  rsp_next.released = 1'b1;
                  if (can_push) begin
                    stack_we = 1'b1;
                    stack_wdata = pg_r;
                    depth_next = depth + DW'(1);
                  end
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      sweep_pg <= '0;
      depth <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      sweep_pg <= sweep_pg_next;
      depth <= depth_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_free_page <= '0;
    end else if (cfg_we) begin
      first_free_page <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    rsp <= rsp_next;
    if (accept) begin
      kind_r <= req.kind;
      pg_r <= PGW'(req_idx);
      bad_r <= req_bad;
    end else if (state == S_SWEEP && sweep_pg == LAST_PAGE) begin
      kind_r <= KIND_INIT;
    end
  end

endmodule
